@@ hdl/mft_pkg.sv @@
// shared types, codes and constants of the manchester frame transceiver
package mft_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LISTEN = 2'd1;
    localparam logic [1:0] OP_SEND   = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // status codes reported in each result item
    localparam logic [2:0] STAT_IDLE     = 3'd0;
    localparam logic [2:0] STAT_LISTEN   = 3'd1;
    localparam logic [2:0] STAT_READ     = 3'd2;
    localparam logic [2:0] STAT_WRITE    = 3'd3;
    localparam logic [2:0] STAT_RECEIVED = 3'd4;
    localparam logic [2:0] STAT_SENT     = 3'd5;
    localparam logic [2:0] STAT_TIMEOUT  = 3'd6;
    localparam logic [2:0] STAT_PROTOCOL = 3'd7;

    // required tick source
    localparam logic [1:0] RATE_STOPPED = 2'd0;
    localparam logic [1:0] RATE_READ    = 2'd1;
    localparam logic [1:0] RATE_WRITE   = 2'd2;

    localparam logic [9:0]  RUN_SHORT_LIMIT = 10'h00F;
    localparam logic [9:0]  RUN_LONG_LIMIT  = 10'h0FF;
    localparam logic [5:0]  FRAME_LAST_POS  = 6'd33;
    localparam logic [5:0]  FRAME_DATA_TOP  = 6'd32;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd4000;

    typedef enum logic [7:0] {
        MODE_IDLE     = 8'b0000_0001,
        MODE_LISTEN   = 8'b0000_0010,
        MODE_READ     = 8'b0000_0100,
        MODE_WRITE    = 8'b0000_1000,
        MODE_RECEIVED = 8'b0001_0000,
        MODE_SENT     = 8'b0010_0000,
        MODE_TIMEOUT  = 8'b0100_0000,
        MODE_PROTOCOL = 8'b1000_0000
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_MID    = 3'd1,
        ERR_NO_CHANGE = 3'd2,
        ERR_BAD_STOP  = 3'd3,
        ERR_PARITY    = 3'd4
    } fault_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] timeout_count;
        logic [9:0]  run_capture;
        logic        half_phase;
        logic [5:0]  bit_index;
        logic [31:0] shift_word;
        fault_t      fault;
        logic        out_level;
    } xcvr_state_t;

    typedef struct packed {
        logic        line_out;
        logic [2:0]  status;
        logic [2:0]  error_kind;
        logic [31:0] rx_frame;
        logic [1:0]  tick_rate;
    } xcvr_result_t;

endpackage

@@ hdl/manchester_frame_transceiver_top.sv @@
// top level of the manchester frame transceiver with its stream channels
//
// usage
//   s_ channel: one item per timer tick or command; s_tuser carries the
//     command (tick, listen, send, stop), s_tdata the line sample and the
//     frame to transmit
//   m_ channel: exactly one result item per input item, in order, with the
//     line level, status, error kind, received word and tick rate
//   cfg_wr_en / cfg_wr_data: loads the listen timeout, write only while idle
// path: an input item is taken into the input register, then the state update
//   writes its result into the result register
// throughput: one item per cycle while the result is not stalled; the only loop
//   is the transceiver state register, updated in a single pass per item
// reset: aresetn low clears both pipeline stages, puts the transceiver in
//   idle with the line high, no fault, and the timeout back to 4000
// stall: while m_tready is low the result stays in place; one more item may
//   wait in the input register, after that s_tready drops
module manchester_frame_transceiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // line_in [0], tx_frame [32:1], zero pad
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // line_out [0], status [3:1], error_kind [6:4],
                                   // rx_frame [38:7], tick_rate [40:39], zero pad
);
    import mft_pkg::*;

    // input register stage
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic        in_line_reg;
    logic [31:0] in_frame_reg;

    // result register stage
    logic         out_valid_reg;
    xcvr_result_t out_res_reg;

    // transceiver state and timeout register
    xcvr_state_t  state_reg;
    xcvr_state_t  state_next;
    xcvr_result_t res_next;
    logic [15:0]  timeout_cfg_reg;

    logic advance;

    // the item in the input register moves on when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg    <= s_tuser;
            in_line_reg  <= s_tdata[0];
            in_frame_reg <= s_tdata[32:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_cfg_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_cfg_reg <= cfg_wr_data;
        end
    end

    mft_step u_step (
        .cur                  (state_reg),
        .op                   (in_op_reg),
        .line_in              (in_line_reg),
        .tx_frame             (in_frame_reg),
        .listen_timeout_ticks (timeout_cfg_reg),
        .nxt                  (state_next),
        .res                  (res_next)
    );

    // state advances once per item, together with the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.timeout_count <= '0;
            state_reg.run_capture   <= '0;
            state_reg.half_phase    <= 1'b0;
            state_reg.bit_index     <= '0;
            state_reg.shift_word    <= '0;
            state_reg.fault         <= ERR_NONE;
            state_reg.out_level     <= 1'b1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.tick_rate, out_res_reg.rx_frame,
                       out_res_reg.error_kind, out_res_reg.status,
                       out_res_reg.line_out};

endmodule

@@ hdl/mft_step.sv @@
// next-state and result logic for one transceiver item
module mft_step (
    input  mft_pkg::xcvr_state_t  cur,
    input  logic [1:0]            op,
    input  logic                  line_in,
    input  logic [31:0]           tx_frame,
    input  logic [15:0]           listen_timeout_ticks,
    output mft_pkg::xcvr_state_t  nxt,
    output mft_pkg::xcvr_result_t res
);
    import mft_pkg::*;

    logic       last_level;
    logic       run_short;
    logic       run_long;
    logic       tx_bit;
    logic [4:0] idx_m1;

    assign last_level = cur.run_capture[0];
    assign run_short  = cur.run_capture > RUN_SHORT_LIMIT;
    assign run_long   = cur.run_capture > RUN_LONG_LIMIT;
    assign idx_m1     = cur.bit_index[4:0] - 5'd1;

    // start and stop bits are ones, data bit n sits at index n+1
    always_comb begin
        if (cur.bit_index == FRAME_LAST_POS || cur.bit_index == 6'd0) begin
            tx_bit = 1'b1;
        end else if (cur.bit_index <= FRAME_DATA_TOP) begin
            tx_bit = cur.shift_word[idx_m1];
        end else begin
            tx_bit = 1'b1;
        end
    end

    always_comb begin
        nxt = cur;
        case (op)
            OP_LISTEN: begin
                nxt.mode          = MODE_LISTEN;
                nxt.timeout_count = listen_timeout_ticks;
                nxt.bit_index     = 6'd0;
                nxt.fault         = ERR_NONE;
            end
            OP_SEND: begin
                nxt.mode       = MODE_WRITE;
                nxt.shift_word = tx_frame;
                nxt.half_phase = 1'b1;
                nxt.bit_index  = FRAME_LAST_POS;
                nxt.fault      = ERR_NONE;
            end
            OP_STOP: begin
                nxt.mode = MODE_IDLE;
            end
            default: begin
                case (cur.mode)
                    MODE_LISTEN: begin
                        if (cur.timeout_count == 16'd0) begin
                            nxt.mode = MODE_TIMEOUT;
                        end else begin
                            if (line_in) begin
                                nxt.shift_word  = '0;
                                nxt.bit_index   = 6'd0;
                                nxt.mode        = MODE_READ;
                                nxt.run_capture = 10'd1;
                                nxt.half_phase  = 1'b1;
                            end
                            nxt.timeout_count = cur.timeout_count - 16'd1;
                        end
                    end
                    MODE_READ: begin
                        if (line_in != last_level) begin
                            if (cur.half_phase && run_short) begin
                                nxt.mode  = MODE_PROTOCOL;
                                nxt.fault = ERR_NO_MID;
                            end else if (cur.half_phase || run_short) begin
                                if (cur.bit_index == FRAME_LAST_POS) begin
                                    if (!last_level) begin
                                        nxt.mode  = MODE_PROTOCOL;
                                        nxt.fault = ERR_BAD_STOP;
                                    end else if (!(^cur.shift_word)) begin
                                        nxt.mode = MODE_RECEIVED;
                                    end else begin
                                        nxt.mode  = MODE_PROTOCOL;
                                        nxt.fault = ERR_PARITY;
                                    end
                                end else begin
                                    nxt.shift_word  = {cur.shift_word[30:0], last_level};
                                    nxt.bit_index   = cur.bit_index + 6'd1;
                                    nxt.half_phase  = 1'b0;
                                    nxt.run_capture = {8'd0, 1'b1, line_in};
                                end
                            end else begin
                                nxt.half_phase  = 1'b1;
                                nxt.run_capture = {8'd0, 1'b1, line_in};
                            end
                        end else if (run_long) begin
                            nxt.mode  = MODE_PROTOCOL;
                            nxt.fault = ERR_NO_CHANGE;
                        end else begin
                            nxt.run_capture = {cur.run_capture[8:0], line_in};
                        end
                    end
                    MODE_WRITE: begin
                        // first half of each bit goes out inverted
                        nxt.out_level = cur.half_phase ? ~tx_bit : tx_bit;
                        if (!cur.half_phase) begin
                            if (cur.bit_index == 6'd0) begin
                                nxt.mode = MODE_SENT;
                            end else begin
                                nxt.bit_index = cur.bit_index - 6'd1;
                            end
                            nxt.half_phase = 1'b1;
                        end else begin
                            nxt.half_phase = 1'b0;
                        end
                    end
                    default: begin
                        nxt = cur;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        res.line_out   = nxt.out_level;
        res.error_kind = nxt.fault;
        res.rx_frame   = (nxt.mode == MODE_RECEIVED) ? nxt.shift_word : 32'd0;
        case (nxt.mode)
            MODE_IDLE:     res.status = STAT_IDLE;
            MODE_LISTEN:   res.status = STAT_LISTEN;
            MODE_READ:     res.status = STAT_READ;
            MODE_WRITE:    res.status = STAT_WRITE;
            MODE_RECEIVED: res.status = STAT_RECEIVED;
            MODE_SENT:     res.status = STAT_SENT;
            MODE_TIMEOUT:  res.status = STAT_TIMEOUT;
            MODE_PROTOCOL: res.status = STAT_PROTOCOL;
            default:       res.status = STAT_IDLE;
        endcase
        case (nxt.mode)
            MODE_LISTEN, MODE_READ: res.tick_rate = RATE_READ;
            MODE_WRITE:             res.tick_rate = RATE_WRITE;
            default:                res.tick_rate = RATE_STOPPED;
        endcase
    end

endmodule

@@ hdl/mft_checker.sv @@
// port-level checks of the manchester frame transceiver and their bind
module mft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import mft_pkg::*;

    logic [2:0] status;
    logic [2:0] error_kind;
    logic [1:0] tick_rate;

    assign status     = m_tdata[3:1];
    assign error_kind = m_tdata[6:4];
    assign tick_rate  = m_tdata[40:39];

    // a stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item offered right after reset");

    // a frame is only received with no fault since the last listen
    a_rx_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == STAT_RECEIVED |-> error_kind == ERR_NONE
            && tick_rate == RATE_STOPPED)
        else $error("received status with a fault or a running tick");

    // a finished transmission leaves the line high
    a_sent_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == STAT_SENT |-> m_tdata[0] && tick_rate == RATE_STOPPED)
        else $error("line not high after sending");

endmodule

bind manchester_frame_transceiver_top mft_checker u_mft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/manchester_frame_transceiver_top_test.sv @@
// self-checking stream testbench for the manchester frame transceiver top level
module manchester_frame_transceiver_top_test;
    import mft_pkg::*;

    // one input item as the sender sees it
    typedef struct {
        logic [1:0]  op;
        logic        line;
        logic [31:0] frame;
    } xcvr_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // line_in [0], tx_frame [32:1], zero pad
    logic [1:0]  s_tuser = '0;    // op [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // line_out [0], status [3:1], error_kind [6:4],
                                  // rx_frame [38:7], tick_rate [40:39], zero pad

    manchester_frame_transceiver_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 aclk = ~aclk;

    // commands waiting for the driver, and line results predicted per accepted item
    xcvr_cmd_t    pending_cmds[$];
    xcvr_result_t predicted_outputs[$];

    int n_queued = 0;
    int n_items = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_received = 0;
    int n_sent = 0;
    int n_faults = 0;
    int n_timeouts = 0;

    // predicted transceiver state, reset values
    logic [2:0]  sim_mode = STAT_IDLE;
    logic [15:0] sim_timeout = '0;
    logic [9:0]  sim_run = '0;
    logic        sim_half = 1'b0;
    logic [5:0]  sim_index = '0;
    logic [31:0] sim_word = '0;
    fault_t      sim_fault = ERR_NONE;
    logic        sim_level = 1'b1;
    logic [15:0] timeout_setting = TIMEOUT_RESET;

    // advance the predicted transceiver by one item and form its result
    function automatic xcvr_result_t step_xcvr(input xcvr_cmd_t c);
        logic         last;
        logic         bit_out;
        xcvr_result_t r;
        if (c.op == OP_LISTEN) begin
            sim_mode = STAT_LISTEN;
            sim_timeout = timeout_setting;
            sim_index = '0;
            sim_fault = ERR_NONE;
        end else if (c.op == OP_SEND) begin
            sim_mode = STAT_WRITE;
            sim_word = c.frame;
            sim_half = 1'b1;
            sim_index = FRAME_LAST_POS;
            sim_fault = ERR_NONE;
        end else if (c.op == OP_STOP) begin
            sim_mode = STAT_IDLE;
        end else if (sim_mode == STAT_LISTEN) begin
            if (sim_timeout == 16'd0) begin
                sim_mode = STAT_TIMEOUT;
            end else begin
                // a high sample opens reception but is not decoded itself
                if (c.line) begin
                    sim_word = '0;
                    sim_index = '0;
                    sim_mode = STAT_READ;
                    sim_run = 10'd1;
                    sim_half = 1'b1;
                end
                sim_timeout = sim_timeout - 16'd1;
            end
        end else if (sim_mode == STAT_READ) begin
            last = sim_run[0];
            if (c.line != last) begin
                if (sim_half && sim_run > RUN_SHORT_LIMIT) begin
                    sim_mode = STAT_PROTOCOL;
                    sim_fault = ERR_NO_MID;
                end else if (sim_half || sim_run > RUN_SHORT_LIMIT) begin
                    // mid-bit transition: a data point
                    if (sim_index == FRAME_LAST_POS) begin
                        if (!last) begin
                            sim_mode = STAT_PROTOCOL;
                            sim_fault = ERR_BAD_STOP;
                        end else if (^sim_word == 1'b0) begin
                            sim_mode = STAT_RECEIVED;
                        end else begin
                            sim_mode = STAT_PROTOCOL;
                            sim_fault = ERR_PARITY;
                        end
                    end else begin
                        sim_word = {sim_word[30:0], last};
                        sim_index = sim_index + 6'd1;
                        sim_half = 1'b0;
                        sim_run = {8'd0, 1'b1, c.line};
                    end
                end else begin
                    sim_half = 1'b1;
                    sim_run = {8'd0, 1'b1, c.line};
                end
            end else if (sim_run > RUN_LONG_LIMIT) begin
                sim_mode = STAT_PROTOCOL;
                sim_fault = ERR_NO_CHANGE;
            end else begin
                sim_run = {sim_run[8:0], c.line};
            end
        end else if (sim_mode == STAT_WRITE) begin
            if (sim_index == FRAME_LAST_POS || sim_index == 6'd0)
                bit_out = 1'b1;
            else if (sim_index <= FRAME_DATA_TOP)
                bit_out = sim_word[sim_index - 6'd1];
            else
                bit_out = 1'b1;
            // first half of each bit goes out inverted
            sim_level = sim_half ? ~bit_out : bit_out;
            if (!sim_half) begin
                if (sim_index == 6'd0)
                    sim_mode = STAT_SENT;
                else
                    sim_index = sim_index - 6'd1;
                sim_half = 1'b1;
            end else begin
                sim_half = 1'b0;
            end
        end
        r.line_out = sim_level;
        r.status = sim_mode;
        r.error_kind = sim_fault;
        r.rx_frame = (sim_mode == STAT_RECEIVED) ? sim_word : 32'd0;
        if (sim_mode == STAT_LISTEN || sim_mode == STAT_READ)
            r.tick_rate = RATE_READ;
        else if (sim_mode == STAT_WRITE)
            r.tick_rate = RATE_WRITE;
        else
            r.tick_rate = RATE_STOPPED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        if (n_mismatch < 40)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     n_results, what, got_v, want_v);
        n_mismatch++;
    endtask

    // driver: one pending command per handshake, then s_tvalid held low at random outside back-to-back stretches
    xcvr_cmd_t cur_cmd;
    int        tx_gap = 0;
    logic      tx_no_idle = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_outputs.push_back(step_xcvr(cur_cmd));
                n_items++;
                tx_gap = tx_no_idle ? 0 : $urandom_range(0, 3);
                // now and then switch to a back-to-back stretch or out of it
                if ($urandom_range(0, 63) == 0)
                    tx_no_idle = ~tx_no_idle;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tuser <= cur_cmd.op;
                    s_tdata <= {7'd0, cur_cmd.frame, cur_cmd.line};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result item field by field, then drop m_tready at random
    int           rx_stall = 0;
    logic         rx_no_idle = 1'b0;
    logic [2:0]   prev_status = STAT_IDLE;
    xcvr_result_t got;
    xcvr_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.line_out = m_tdata[0];
                got.status = m_tdata[3:1];
                got.error_kind = m_tdata[6:4];
                got.rx_frame = m_tdata[38:7];
                got.tick_rate = m_tdata[40:39];
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("result with nothing predicted", m_tdata, 0);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (got.line_out !== want.line_out)
                        report_mismatch("line_out", got.line_out, want.line_out);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.error_kind !== want.error_kind)
                        report_mismatch("error_kind", got.error_kind, want.error_kind);
                    if (got.rx_frame !== want.rx_frame)
                        report_mismatch("rx_frame", got.rx_frame, want.rx_frame);
                    if (got.tick_rate !== want.tick_rate)
                        report_mismatch("tick_rate", got.tick_rate, want.tick_rate);
                    // count frame endings once each, not every tick that holds them
                    if (want.status != prev_status) begin
                        if (want.status == STAT_RECEIVED) n_received++;
                        if (want.status == STAT_SENT) n_sent++;
                        if (want.status == STAT_PROTOCOL) n_faults++;
                        if (want.status == STAT_TIMEOUT) n_timeouts++;
                    end
                    prev_status = want.status;
                end
                n_results++;
                rx_stall = rx_no_idle ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0)
                    rx_no_idle = ~rx_no_idle;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [1:0] op, input logic line, input logic [31:0] frame);
        xcvr_cmd_t c;
        c.op = op;
        c.line = line;
        c.frame = frame;
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    // one manchester half-bit on the receive line, n read-rate ticks long
    task automatic add_half(input logic level, input int n);
        repeat (n) push_item(OP_TICK, level, $urandom);
    endtask

    // every queued item has come back, plus a short margin for the pipeline
    task automatic drain();
        while (n_results < n_queued) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_timeout(input logic [15:0] v);
        drain();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        timeout_setting = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mix of received frames, sends, listen timeouts and random noise
    task automatic queue_phase(input int n_new);
        int          target;
        int          wave_start;
        int          bad_bit;
        int          lo;
        int          hi;
        int          k;
        int          n;
        logic        b;
        logic [1:0]  cmd_op;
        logic [31:0] word;
        target = n_queued + n_new;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // well-formed frame on the line, sometimes damaged
                    push_item(OP_LISTEN, 1'($urandom_range(0, 1)), $urandom);
                    repeat ($urandom_range(0, 6)) push_item(OP_TICK, 1'b0, $urandom);
                    word = $urandom;
                    if ($urandom_range(0, 3) != 0 && ^word)
                        word[0] = ~word[0];
                    bad_bit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 33) : -1;
                    wave_start = pending_cmds.size();
                    for (int i = 0; i < 34; i++) begin
                        if (i == 0)
                            b = 1'b1;
                        else if (i == 33)
                            b = ($urandom_range(0, 7) != 0);
                        else
                            b = word[32 - i];
                        // halves of 2 or 3 ticks, or 1 to 12 ticks for the stretched bit
                        lo = (i == bad_bit) ? 1 : 2;
                        hi = (i == bad_bit) ? 12 : 3;
                        add_half(b, $urandom_range(lo, hi));
                        add_half(~b, $urandom_range(lo, hi));
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        k = $urandom_range(wave_start, pending_cmds.size() - 1);
                        pending_cmds[k].line = ~pending_cmds[k].line;
                    end
                    repeat ($urandom_range(1, 4))
                        push_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom);
                end
                4, 5, 6: begin
                    // send a frame, at times cut short by another command
                    case ($urandom_range(0, 7))
                        0: word = 32'h0000_0000;
                        1: word = 32'hFFFF_FFFF;
                        default: word = $urandom;
                    endcase
                    push_item(OP_SEND, 1'($urandom_range(0, 1)), word);
                    if ($urandom_range(0, 5) == 0) begin
                        repeat ($urandom_range(1, 67))
                            push_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom);
                        cmd_op = 2'($urandom_range(1, 3));
                        push_item(cmd_op, 1'($urandom_range(0, 1)), $urandom);
                    end else begin
                        repeat (68 + $urandom_range(0, 4))
                            push_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom);
                    end
                end
                7: begin
                    // quiet line while listening, long enough to time out where possible
                    push_item(OP_LISTEN, 1'($urandom_range(0, 1)), $urandom);
                    n = (timeout_setting <= 16'd40) ? timeout_setting + $urandom_range(1, 3)
                                                    : $urandom_range(1, 8);
                    repeat (n) push_item(OP_TICK, 1'b0, $urandom);
                end
                default: begin
                    repeat ($urandom_range(5, 30)) begin
                        if ($urandom_range(0, 7) < 5)
                            cmd_op = OP_TICK;
                        else
                            cmd_op = 2'($urandom_range(1, 3));
                        push_item(cmd_op, 1'($urandom_range(0, 1)), $urandom);
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle ticks, an aborted reception, restarted and aborted sends,
        // a long high run while reading, and stop keeping the fault
        push_item(OP_TICK, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_STOP, 1'b0, 32'h0000_0000);
        push_item(OP_LISTEN, 1'b1, 32'hFFFF_FFFF);
        push_item(OP_TICK, 1'b0, 32'h0000_0000);
        push_item(OP_TICK, 1'b1, 32'h0000_0000);
        push_item(OP_TICK, 1'b1, 32'h0000_0000);
        push_item(OP_TICK, 1'b0, 32'h0000_0000);
        push_item(OP_STOP, 1'b1, 32'h0000_0000);
        push_item(OP_TICK, 1'b1, 32'h0000_0000);
        push_item(OP_SEND, 1'b0, 32'hFFFF_FFFF);
        repeat (3) push_item(OP_TICK, 1'b0, 32'h0000_0000);
        push_item(OP_SEND, 1'b1, 32'h0000_0000);
        repeat (2) push_item(OP_TICK, 1'b1, 32'h0000_0000);
        push_item(OP_LISTEN, 1'b0, 32'h8000_0001);
        repeat (10) push_item(OP_TICK, 1'b1, 32'h0000_0000);
        push_item(OP_STOP, 1'b0, 32'h0000_0000);
        push_item(OP_TICK, 1'b0, 32'h0000_0000);

        // random phases, each under its own listen timeout
        queue_phase(270);
        load_timeout(16'd0);
        queue_phase(270);
        load_timeout(16'hFFFF);
        queue_phase(270);
        load_timeout(16'd1);
        queue_phase(270);
        load_timeout(16'($urandom_range(2, 30)));
        queue_phase(270);
        load_timeout(16'd200);
        queue_phase(270);

        drain();
        repeat (8) @(posedge aclk);
        $display("covered %0d items and %0d results, %0d mismatches", n_items, n_results,
                 n_mismatch);
        $display("frames received %0d, sent %0d, protocol faults %0d, listen timeouts %0d",
                 n_received, n_sent, n_faults, n_timeouts);
        if (n_mismatch == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(12 * 300000);
        $display("timeout: %0d of %0d results seen", n_results, n_queued);
        $display("Some tests failed");
        $finish;
    end

endmodule
